// ----- src/hcbp_pkg.sv -----
`timescale 1ns / 1ps
// hcbp_pkg: shared types and constants of the huffman code bit packer
// no dependencies

package hcbp_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  // fixed widths of the port fields
  localparam int KIND_W = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int PATH_W = 32;
  localparam int BYTE_W = 8;
  localparam int PAD_W  = 3;

  // depth of the command queue between front and back
  localparam int Q_DEPTH = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

endpackage

// ----- src/hcbp_ram.sv -----
`timescale 1ns / 1ps
// hcbp_ram: generic single write port ram with registered read
// no dependencies

module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/hcbp_front.sv -----
`timescale 1ns / 1ps
// hcbp_front: accepts input words, writes and reads the code table,
// hands encode and flush commands to the queue; uses hcbp_pkg, hcbp_ram

module hcbp_front #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic [hcbp_pkg::KIND_W-1:0]                  kind_i,
  input  logic [hcbp_pkg::SYM_W-1:0]                   symbol_i,
  input  logic [hcbp_pkg::LEN_W-1:0]                   code_length_i,
  input  logic [hcbp_pkg::PATH_W-1:0]                  code_path_i,
  output logic                                         push_valid_o,
  input  logic                                         push_ready_i,
  output logic [$clog2(MAX_CODE_LEN+1)+MAX_CODE_LEN:0] push_data_o
);

  import hcbp_pkg::*;

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int EW = LW + MAX_CODE_LEN;
  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

  logic          stg_vld_q, stg_vld_d;
  logic          stg_flush_q, stg_flush_d;
  logic          accept, in_range;
  logic          ram_we, ram_re;
  logic [LW-1:0] len_sat;
  logic [EW-1:0] ram_rdata;

  assign in_stall_o = stg_vld_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = {1'b0, symbol_i} < SYM_LIMIT;

  // saturate the loaded length
  assign len_sat = (code_length_i > LEN_W'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                           : code_length_i[LW-1:0];

  hcbp_ram #(
    .WIDTH(EW),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(symbol_i[AW-1:0]),
    .wdata_i({len_sat, code_path_i[MAX_CODE_LEN-1:0]}),
    .re_i   (ram_re),
    .raddr_i(symbol_i[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    stg_vld_d   = stg_vld_q && !push_ready_i;
    stg_flush_d = stg_flush_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (accept) begin
      unique case (kind_e'(kind_i))
        KIND_LOAD: begin
          ram_we = in_range;
        end
        KIND_ENCODE: begin
          ram_re = in_range;
          if (in_range) begin
            stg_vld_d   = 1'b1;
            stg_flush_d = 1'b0;
          end
        end
        KIND_FLUSH: begin
          stg_vld_d   = 1'b1;
          stg_flush_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q   <= 1'b0;
      stg_flush_q <= 1'b0;
    end else begin
      stg_vld_q   <= stg_vld_d;
      stg_flush_q <= stg_flush_d;
    end
  end

  assign push_valid_o = stg_vld_q;
  assign push_data_o  = {stg_flush_q, ram_rdata};

endmodule

// ----- src/hcbp_fifo.sv -----
`timescale 1ns / 1ps
// hcbp_fifo: short command queue between front and back
// uses hcbp_pkg for its depth

module hcbp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  import hcbp_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [Q_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CW'(Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

endmodule

// ----- src/hcbp_back.sv -----
`timescale 1ns / 1ps
// hcbp_back: bit packer, appends code bits and emits one byte per cycle while the output is not stalled
// uses hcbp_pkg

module hcbp_back #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         pop_valid_i,
  output logic                                         pop_o,
  input  logic [$clog2(MAX_CODE_LEN+1)+MAX_CODE_LEN:0] pop_data_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output logic [hcbp_pkg::BYTE_W-1:0]                  out_byte_o,
  output logic                                         byte_valid_o,
  output logic [hcbp_pkg::PAD_W-1:0]                   pad_bits_o,
  output logic                                         last_o
);

  import hcbp_pkg::*;

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int CMD_W = LW + MAX_CODE_LEN + 1;
  localparam int BW = MAX_CODE_LEN + BYTE_W;
  localparam int CW = $clog2(MAX_CODE_LEN + BYTE_W);

  logic [BW-1:0]           buf_q, buf_d, rev;
  logic [CW-1:0]           cnt_q, cnt_d, rest;
  logic                    busy, out_free, emit;
  logic                    cmd_flush;
  logic [LW-1:0]           cmd_len;
  logic [MAX_CODE_LEN-1:0] cmd_path;
  logic                    out_vld_q;
  logic [BYTE_W-1:0]       out_byte_q, out_byte_d;
  logic                    out_bvld_q, out_bvld_d;
  logic [PAD_W-1:0]        out_pad_q, out_pad_d;
  logic                    out_last_q, out_last_d;

  assign cmd_flush = pop_data_i[CMD_W-1];
  assign cmd_len   = pop_data_i[CMD_W-2 -: LW];
  assign cmd_path  = pop_data_i[MAX_CODE_LEN-1:0];

  // a full byte waits in the top of the buffer
  assign busy     = cnt_q >= CW'(BYTE_W);
  assign out_free = !out_vld_q || !out_stall_i;
  assign rest     = cnt_q - CW'(BYTE_W);

  // path bit 0 goes first, so it lands in the top bit; bits past the length drop
  always_comb begin
    rev = '0;
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      rev[BW-1-i] = cmd_path[i] && (LW'(i) < cmd_len);
    end
  end

  always_comb begin
    buf_d      = buf_q;
    cnt_d      = cnt_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    out_byte_d = out_byte_q;
    out_bvld_d = out_bvld_q;
    out_pad_d  = out_pad_q;
    out_last_d = out_last_q;
    if (busy) begin
      if (out_free) begin
        emit       = 1'b1;
        out_byte_d = buf_q[BW-1 -: BYTE_W];
        out_bvld_d = 1'b1;
        out_pad_d  = '0;
        out_last_d = rest < CW'(BYTE_W);
        buf_d      = buf_q << BYTE_W;
        cnt_d      = rest;
      end
    end else if (pop_valid_i) begin
      if (cmd_flush) begin
        if (out_free) begin
          emit       = 1'b1;
          pop_o      = 1'b1;
          out_byte_d = buf_q[BW-1 -: BYTE_W];
          out_bvld_d = cnt_q[2:0] != '0;
          // an empty buffer wraps eight to zero
          out_pad_d  = PAD_W'(4'd8 - {1'b0, cnt_q[2:0]});
          out_last_d = 1'b1;
          buf_d      = '0;
          cnt_d      = '0;
        end
      end else begin
        pop_o = 1'b1;
        buf_d = buf_q | (rev >> cnt_q[2:0]);
        cnt_d = cnt_q + CW'(cmd_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      buf_q     <= buf_d;
      cnt_q     <= cnt_d;
      out_vld_q <= emit || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_bvld_q <= out_bvld_d;
    out_pad_q  <= out_pad_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_vld_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = out_bvld_q;
  assign pad_bits_o   = out_pad_q;
  assign last_o       = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_CODE_LEN + BYTE_W - 1))
    else $error("packer bit count overflow");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy)
    else $error("command taken while a byte is pending");

  a_empty_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_bvld_q |-> out_byte_q == '0 && out_pad_q == '0 && out_last_q)
    else $error("empty flush result carries data");

endmodule

// ----- src/huffman_code_bit_packer_core.sv -----
`timescale 1ns / 1ps
// flow: an encode word reads the code table into the front stage register when accepted,
//   is then written into the queue and merged into the packer buffer; its first byte
//   is then registered at the output; a load writes the table when accepted
// throughput: the packer pops no command while a whole byte waits; it emits one byte a
//   cycle while the output is not stalled, and a flush's byte leaves as the flush pops
// reset: stage, queue, packer buffer and output valid clear; table entries undefined

module huffman_code_bit_packer_core #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [hcbp_pkg::KIND_W-1:0] kind_i,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol_i,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length_i,
  input  logic [hcbp_pkg::PATH_W-1:0] code_path_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hcbp_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        byte_valid_o,
  output logic [hcbp_pkg::PAD_W-1:0]  pad_bits_o,
  output logic                        last_o
);

  import hcbp_pkg::*;

  // command: flush flag, code length, code path
  localparam int CMD_W = $clog2(MAX_CODE_LEN + 1) + MAX_CODE_LEN + 1;

  logic             f_push_valid, f_push_ready;
  logic [CMD_W-1:0] f_push_data;
  logic             q_pop_valid, q_pop;
  logic [CMD_W-1:0] q_pop_data;

  // front: table writes on load, table read on encode, commands out
  hcbp_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .symbol_i     (symbol_i),
    .code_length_i(code_length_i),
    .code_path_i  (code_path_i),
    .push_valid_o (f_push_valid),
    .push_ready_i (f_push_ready),
    .push_data_o  (f_push_data)
  );

  // queue lets the front keep loading while the packer drains bytes
  hcbp_fifo #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_push_valid),
    .push_ready_o(f_push_ready),
    .push_data_i (f_push_data),
    .pop_valid_o (q_pop_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data)
  );

  // back: bit packer with its own output register
  hcbp_back #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_o       (q_pop),
    .pop_data_i  (q_pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .pad_bits_o  (pad_bits_o),
    .last_o      (last_o)
  );

endmodule

// ----- tb/huffman_code_bit_packer_core_tb.sv -----
`timescale 1ns / 1ps
// huffman_code_bit_packer_core_tb: self-checking bench for the code bit packer core
// depends on hcbp_pkg and huffman_code_bit_packer_core; predicts every result word
// from its own copy of the code table and packer buffer

module huffman_code_bit_packer_core_tb;
  import hcbp_pkg::*;

  // kind code the block must drop without any effect
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [PATH_W-1:0] code_path;
  } word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [PAD_W-1:0]  pad_bits;
    logic              last;
  } result_t;

  // dut connections; the inputs are known from time zero
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [KIND_W-1:0] kind_i        = '0;
  logic [SYM_W-1:0]  symbol_i      = '0;
  logic [LEN_W-1:0]  code_length_i = '0;
  logic [PATH_W-1:0] code_path_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [BYTE_W-1:0] out_byte_o;
  logic              byte_valid_o;
  logic [PAD_W-1:0]  pad_bits_o;
  logic              last_o;

  huffman_code_bit_packer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .symbol_i      (symbol_i),
    .code_length_i (code_length_i),
    .code_path_i   (code_path_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .pad_bits_o    (pad_bits_o),
    .last_o        (last_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // words still to be offered, and the word now on the input port
  word_t   word_q[$];
  word_t   held_word = '0;
  // packed bytes still owed by the block, oldest first
  result_t byte_q[$];

  // predicted state of the block
  logic [LEN_W-1:0]  len_tab  [SYMBOL_COUNT_DEF];
  logic [PATH_W-1:0] path_tab [SYMBOL_COUNT_DEF];
  logic [BYTE_W-1:0] partial_acc = '0;
  int                fill_cnt    = 0;

  // stimulus side bookkeeping: which table entries have been loaded so far
  logic gen_loaded [SYMBOL_COUNT_DEF];
  int   gen_syms[$];

  // idling knobs, percent of cycles
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_armed;
  int   hold_left;

  int mismatches = 0;
  int cycle_cnt  = 0;

  // predicts one word: table load, code bits packed with the bytes owed, or flush result
  function automatic void pack_word(input word_t w);
    result_t          made [4];
    int               n_made;
    int               n_bits;
    int               i;
    logic [PATH_W-1:0] bits;
    n_made = 0;
    case (w.kind)
      KIND_LOAD: begin
        // lengths beyond the longest code saturate
        len_tab[w.symbol]  = (w.code_length > MAX_CODE_LEN_DEF) ?
                             LEN_W'(MAX_CODE_LEN_DEF) : w.code_length;
        path_tab[w.symbol] = w.code_path;
      end
      KIND_ENCODE: begin
        n_bits = len_tab[w.symbol];
        bits   = path_tab[w.symbol];
        // path bit 0 goes first, filling from the top of the byte
        for (i = 0; i < n_bits; i++) begin
          partial_acc[7 - fill_cnt] = bits[i];
          fill_cnt++;
          if (fill_cnt == 8) begin
            made[n_made] = '{out_byte: partial_acc, byte_valid: 1'b1,
                             pad_bits: '0, last: 1'b0};
            n_made++;
            partial_acc = '0;
            fill_cnt    = 0;
          end
        end
        if (n_made > 0) made[n_made - 1].last = 1'b1;
        for (i = 0; i < n_made; i++) byte_q.push_back(made[i]);
      end
      KIND_FLUSH: begin
        // an empty buffer still answers, with no data and no pad count
        if (fill_cnt > 0) begin
          byte_q.push_back('{out_byte: partial_acc, byte_valid: 1'b1,
                             pad_bits: PAD_W'(8 - fill_cnt), last: 1'b1});
        end else begin
          byte_q.push_back('{out_byte: '0, byte_valid: 1'b0, pad_bits: '0, last: 1'b1});
        end
        partial_acc = '0;
        fill_cnt    = 0;
      end
      default: begin
        // unused kind: no state change, nothing owed
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input result_t want, input result_t seen);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) begin
      $display("%0t: %s: byte %h/%h valid %b/%b pad %0d/%0d last %b/%b (want/got)",
               $time, what, want.out_byte, seen.out_byte, want.byte_valid,
               seen.byte_valid, want.pad_bits, seen.pad_bits, want.last, seen.last);
    end
  endtask

  // driver: predicts on acceptance, then offers the next pending word unless idling
  always @(posedge clk_i or negedge rst_ni) begin
    word_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) pack_word(held_word);
      // a stalled word stays put; otherwise choose between a new word and a gap
      if (!in_valid_i || !in_stall_o) begin
        if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = word_q.pop_front();
          held_word     <= nxt;
          kind_i        <= nxt.kind;
          symbol_i      <= nxt.symbol;
          code_length_i <= nxt.code_length;
          code_path_i   <= nxt.code_path;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b0;
    end else if (hold_req && !hold_armed) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: every accepted result word against the oldest owed byte
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{out_byte: out_byte_o, byte_valid: byte_valid_o,
               pad_bits: pad_bits_o, last: last_o};
      if (byte_q.size() == 0) begin
        flag_mismatch("result with nothing owed", '0, seen);
      end else begin
        want = byte_q.pop_front();
        if (seen !== want) flag_mismatch("result mismatch", want, seen);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic post_word(input logic [KIND_W-1:0] kind, input int sym,
                           input int len, input logic [PATH_W-1:0] path);
    word_t w;
    w = '{kind: kind, symbol: SYM_W'(sym), code_length: LEN_W'(len), code_path: path};
    word_q.push_back(w);
    if (kind == KIND_LOAD && !gen_loaded[sym]) begin
      gen_loaded[sym] = 1'b1;
      gen_syms.push_back(sym);
    end
  endtask

  // mostly short codes, a few long ones, some empty and some oversize
  function automatic int pick_length();
    int t;
    t = $urandom_range(99);
    if (t < 10) return 0;
    if (t < 70) return $urandom_range(12, 1);
    if (t < 92) return $urandom_range(32, 13);
    return $urandom_range(63, 33);
  endfunction

  // random words: table loads, encodes of loaded entries only, flushes, unused-kind noise
  task automatic post_random(input int count);
    int done;
    int r;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (gen_syms.size() == 0 || r < 22) begin
        post_word(KIND_LOAD, $urandom_range(255), pick_length(), $urandom);
        done++;
      end else if (r < 82) begin
        post_word(KIND_ENCODE, gen_syms[$urandom_range(gen_syms.size() - 1)], 0, '0);
        done++;
      end else if (r < 95) begin
        post_word(KIND_FLUSH, $urandom_range(255), $urandom_range(63), $urandom);
        done++;
      end else begin
        // ignored by the block, not counted
        post_word(KIND_UNUSED, $urandom_range(255), $urandom_range(63), $urandom);
      end
    end
  endtask

  // lets every pending word go through the input port
  task automatic drain_words();
    while (word_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  initial begin
    foreach (gen_loaded[k]) gen_loaded[k] = 1'b0;
    foreach (len_tab[k]) begin
      len_tab[k]  = '0;
      path_tab[k] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words, no idling
    post_word(KIND_FLUSH, 0, 0, '0);                   // flush on an empty buffer
    post_word(KIND_LOAD, 0, 0, 32'hFFFF_FFFF);          // empty code, path ignored
    post_word(KIND_LOAD, 255, 32, 32'hFFFF_FFFF);       // longest code, all ones
    post_word(KIND_LOAD, 1, 63, 32'h8000_0001);         // oversize length saturates
    post_word(KIND_LOAD, 3, 3, 32'hFFFF_FFFD);          // path bits above the length ignored
    post_word(KIND_LOAD, 2, 33, 32'h0000_FFFF);
    post_word(KIND_ENCODE, 0, 0, '0);                   // no bits, no result
    post_word(KIND_UNUSED, 255, 63, 32'hFFFF_FFFF);     // unused kind dropped
    post_word(KIND_ENCODE, 3, 0, '0);                   // partial byte only
    post_word(KIND_FLUSH, 0, 0, '0);                    // partial byte with pad count
    post_word(KIND_ENCODE, 255, 0, '0);                 // four whole bytes, aligned
    post_word(KIND_ENCODE, 1, 0, '0);
    post_word(KIND_ENCODE, 3, 0, '0);
    post_word(KIND_ENCODE, 255, 0, '0);                 // four bytes across a boundary
    post_word(KIND_ENCODE, 2, 0, '0);
    post_word(KIND_FLUSH, 0, 0, '0);
    post_word(KIND_FLUSH, 255, 63, 32'hFFFF_FFFF);      // second flush finds it empty
    post_word(KIND_LOAD, 4, 8, 32'h0000_00A5);
    post_word(KIND_ENCODE, 4, 0, '0);                   // exactly one byte
    post_word(KIND_LOAD, 5, 1, 32'h0000_0001);
    post_word(KIND_ENCODE, 5, 0, '0);
    post_word(KIND_FLUSH, 0, 0, '0);                    // pad of seven
    drain_words();

    // random words while the receiver holds off for a long stretch
    hold_req = 1'b1;
    post_random(20);
    drain_words();

    idle_pct  = 84;
    stall_pct = 0;
    post_random(20);
    drain_words();

    idle_pct  = 0;
    stall_pct = 84;
    post_random(20);
    drain_words();

    idle_pct  = 37;
    stall_pct = 37;
    post_random(20);
    post_word(KIND_FLUSH, 0, 0, '0);
    drain_words();

    // wait for every owed byte, then a short tail for strays
    while (byte_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
